@@ sv/eno3_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ENO3 reconstruction package
// Shared widths, payload types, stencil codes and the ENO coefficient table.
// ----------------------------------------------------------------------------
package eno3_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int COMPS       = 3;
   localparam int TAPS        = 5;
   localparam int COEF_WIDTH  = 5;
   // coefficient magnitudes add up to at most 20 sixths
   localparam int SUM_WIDTH   = VALUE_WIDTH + 5;
   localparam int DIFF_WIDTH  = VALUE_WIDTH + 2;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef value_type [TAPS-1:0]          taps_type;
   typedef taps_type [COMPS-1:0]          window_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;
   typedef logic signed [COEF_WIDTH-1:0]  coef_type;
   typedef logic [1:0]                    stencil_type;

   typedef struct packed {
      sum_type [COMPS-1:0] right;
      sum_type [COMPS-1:0] left;
   } sums_type;

   typedef struct packed {
      value_type [COMPS-1:0] right;
      value_type [COMPS-1:0] left;
   } faces_type;

   typedef struct packed {
      logic last_in_run;
      logic row_done;
   } tag_type;

   // stencil start relative to the cell: i, i-1, i-2
   localparam stencil_type STENCIL_RIGHT  = 2'd0;
   localparam stencil_type STENCIL_CENTER = 2'd1;
   localparam stencil_type STENCIL_LEFT   = 2'd2;

   localparam logic SIDE_RIGHT = 1'b0;
   localparam logic SIDE_LEFT  = 1'b1;

   localparam logic ORDER_SECOND = 1'b0;
   localparam logic ORDER_THIRD  = 1'b1;

   // coefficients in sixths: [order][side][stencil][tap]
   localparam coef_type COEF6 [2][2][3][TAPS] = '{
      '{ '{ '{5'sd0, 5'sd0, 5'sd3, 5'sd3, 5'sd0},
            '{5'sd0, -5'sd3, 5'sd9, 5'sd0, 5'sd0},
            '{5'sd0, -5'sd3, 5'sd9, 5'sd0, 5'sd0} },
         '{ '{5'sd0, 5'sd0, 5'sd9, -5'sd3, 5'sd0},
            '{5'sd0, 5'sd3, 5'sd3, 5'sd0, 5'sd0},
            '{5'sd0, 5'sd3, 5'sd3, 5'sd0, 5'sd0} } },
      '{ '{ '{5'sd0, 5'sd0, 5'sd2, 5'sd5, -5'sd1},
            '{5'sd0, -5'sd1, 5'sd5, 5'sd2, 5'sd0},
            '{5'sd2, -5'sd7, 5'sd11, 5'sd0, 5'sd0} },
         '{ '{5'sd0, 5'sd0, 5'sd11, -5'sd7, 5'sd2},
            '{5'sd0, 5'sd2, 5'sd5, -5'sd1, 5'sd0},
            '{-5'sd1, 5'sd5, 5'sd2, 5'sd0, 5'sd0} } }
   };

endpackage

@@ sv/eno3_interface_reconstruction_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ENO3 interface reconstruction
// Second- or third-order ENO reconstruction of right and left interface
// values for density, momentum and energy, one cell per request.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// req      in         req_valid/req_ready  cell averages, first/last cell flags
// rsp      out        rsp_valid/rsp_ready  right/left faces, run and row flags
// csr      in         csr_write_enable     third_order_enable
//
// One request per cycle while nothing stalls; the request that completes a
// window is registered, then its sums (stencil), then its result (rounding).
// A row-end flush of three results holds req_ready low until the last issues.
// rsp_ready low fills the three stages, then req_ready drops.
// Synchronous reset empties the pipeline, closes the row, selects third order.
// ----------------------------------------------------------------------------
module eno3_interface_reconstruction_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  eno3_pkg::value_type   req_density,
   input  eno3_pkg::value_type   req_momentum,
   input  eno3_pkg::value_type   req_energy,
   input  logic                  req_first_cell,
   input  logic                  req_last_cell,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output eno3_pkg::value_type   rsp_right_face_density,
   output eno3_pkg::value_type   rsp_right_face_momentum,
   output eno3_pkg::value_type   rsp_right_face_energy,
   output eno3_pkg::value_type   rsp_left_face_density,
   output eno3_pkg::value_type   rsp_left_face_momentum,
   output eno3_pkg::value_type   rsp_left_face_energy,
   output logic                  rsp_last_in_run,
   output logic                  rsp_row_done,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data
);
   import eno3_pkg::*;

   logic       third_order_ff;

   logic       issue_valid, issue_ready;
   window_type issue_window;
   tag_type    issue_tag;

   logic       sums_valid, sums_ready;
   sums_type   sums;
   tag_type    sums_tag;

   faces_type  faces;
   tag_type    faces_tag;

   always_ff @(posedge clock) begin
      if (reset) begin
         third_order_ff <= 1'b1;
      end else if (csr_write_enable) begin
         third_order_ff <= csr_write_data;
      end
   end

   eno3_window u_window (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_density    (req_density),
      .req_momentum   (req_momentum),
      .req_energy     (req_energy),
      .req_first_cell (req_first_cell),
      .req_last_cell  (req_last_cell),
      .issue_valid    (issue_valid),
      .issue_ready    (issue_ready),
      .issue_window   (issue_window),
      .issue_tag      (issue_tag)
   );

   eno3_stencil u_stencil (
      .clock              (clock),
      .reset              (reset),
      .third_order_enable (third_order_ff),
      .in_valid           (issue_valid),
      .in_ready           (issue_ready),
      .in_window          (issue_window),
      .in_tag             (issue_tag),
      .out_valid          (sums_valid),
      .out_ready          (sums_ready),
      .out_sums           (sums),
      .out_tag            (sums_tag)
   );

   eno3_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sums_valid),
      .in_ready  (sums_ready),
      .in_sums   (sums),
      .in_tag    (sums_tag),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_faces (faces),
      .rsp_tag   (faces_tag)
   );

   assign rsp_right_face_density  = faces.right[0];
   assign rsp_right_face_momentum = faces.right[1];
   assign rsp_right_face_energy   = faces.right[2];
   assign rsp_left_face_density   = faces.left[0];
   assign rsp_left_face_momentum  = faces.left[1];
   assign rsp_left_face_energy    = faces.left[2];
   assign rsp_last_in_run         = faces_tag.last_in_run;
   assign rsp_row_done            = faces_tag.row_done;

endmodule

@@ sv/eno3_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ENO3 cell window
// Holds the five-cell window per component and the row count, takes requests
// and issues one reconstruction per unstalled cycle, row-end flush included.
// ----------------------------------------------------------------------------
module eno3_window (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  eno3_pkg::value_type    req_density,
   input  eno3_pkg::value_type    req_momentum,
   input  eno3_pkg::value_type    req_energy,
   input  logic                   req_first_cell,
   input  logic                   req_last_cell,
   output logic                   issue_valid,
   input  logic                   issue_ready,
   output eno3_pkg::window_type   issue_window,
   output eno3_pkg::tag_type      issue_tag
);
   import eno3_pkg::*;

   window_type win_ff, win_in;
   logic [2:0] seen_ff, seen_in;
   // pending results of the held request: bit n = window shifted by n replicas
   logic [2:0] mask_ff, mask_in;

   logic       accept;
   logic       restart;
   logic [2:0] seen_new;
   logic [2:0] mask_new;
   logic [2:0] sel;
   logic [2:0] mask_rest;
   logic [1:0] phase;
   value_type  req_value [COMPS];

   assign req_value[0] = req_density;
   assign req_value[1] = req_momentum;
   assign req_value[2] = req_energy;

   assign issue_valid = |mask_ff;
   assign sel         = mask_ff & (~mask_ff + 3'd1);
   assign mask_rest   = mask_ff & ~sel;
   assign req_ready   = !issue_valid || (issue_ready && mask_rest == 3'd0);
   assign accept      = req_valid && req_ready;
   assign restart     = req_first_cell || seen_ff == 3'd0;

   always_comb begin
      phase = sel[1] ? 2'd1 : (sel[2] ? 2'd2 : 2'd0);
      issue_tag.last_in_run = mask_rest == 3'd0;
      issue_tag.row_done    = sel[2];
   end

   // flushed cells past the row end replicate the last cell
   always_comb begin
      logic [2:0] idx;
      for (int c = 0; c < COMPS; c++) begin
         for (int t = 0; t < TAPS; t++) begin
            idx = 3'(t) + 3'(phase);
            if (idx > 3'(TAPS - 1)) begin
               idx = 3'(TAPS - 1);
            end
            issue_window[c][t] = win_ff[c][idx];
         end
      end
   end

   always_comb begin
      if (restart) begin
         seen_new = 3'd1;
      end else if (seen_ff == 3'd7) begin
         seen_new = seen_ff;
      end else begin
         seen_new = seen_ff + 3'd1;
      end

      if (req_last_cell) begin
         mask_new = {1'b1, seen_new >= 3'd2, seen_new >= 3'd3};
      end else begin
         mask_new = {2'b00, seen_new >= 3'd3};
      end

      for (int c = 0; c < COMPS; c++) begin
         for (int t = 0; t < TAPS - 1; t++) begin
            win_in[c][t] = restart ? req_value[c] : win_ff[c][t+1];
         end
         win_in[c][TAPS-1] = req_value[c];
      end

      if (accept) begin
         seen_in = req_last_cell ? 3'd0 : seen_new;
         mask_in = mask_new;
      end else begin
         seen_in = seen_ff;
         mask_in = (issue_valid && issue_ready) ? mask_rest : mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 3'd0;
         mask_ff <= 3'd0;
      end else begin
         seen_ff <= seen_in;
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

   a_last_closes_row: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_cell |=> seen_ff == 3'd0)
      else $error("row count not cleared after last cell");

   a_window_held_in_flush: assert property (@(posedge clock) disable iff (reset)
      (mask_ff & (mask_ff - 3'd1)) != 3'd0 |=> $stable(win_ff))
      else $error("window changed while a flush was pending");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      issue_valid && issue_tag.row_done |-> issue_tag.last_in_run)
      else $error("row end issued before the last result of its request");

endmodule

@@ sv/eno3_stencil.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ENO3 stencil stage
// Picks the ENO stencil per component from first and second differences and
// registers the face sums in sixths.
// ----------------------------------------------------------------------------
module eno3_stencil (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   third_order_enable,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  eno3_pkg::window_type   in_window,
   input  eno3_pkg::tag_type      in_tag,
   output logic                   out_valid,
   input  logic                   out_ready,
   output eno3_pkg::sums_type     out_sums,
   output eno3_pkg::tag_type      out_tag
);
   import eno3_pkg::*;

   typedef logic signed [DIFF_WIDTH-1:0] diff_type;
   typedef logic [DIFF_WIDTH-1:0]        mag_type;

   logic     valid_ff, valid_in;
   sums_type sums_ff, sums_in;
   tag_type  tag_ff;
   logic     order;

   function automatic mag_type mag(input diff_type x);
      return x < 0 ? mag_type'(-x) : mag_type'(x);
   endfunction

   assign order     = third_order_enable ? ORDER_THIRD : ORDER_SECOND;
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_sums  = sums_ff;
   assign out_tag   = tag_ff;

   always_comb begin
      diff_type    dmm, dm, dp, dpp;
      stencil_type st;
      sum_type     acc_r, acc_l;
      for (int c = 0; c < COMPS; c++) begin
         dmm = DIFF_WIDTH'(in_window[c][1]) - DIFF_WIDTH'(in_window[c][0]);
         dm  = DIFF_WIDTH'(in_window[c][2]) - DIFF_WIDTH'(in_window[c][1]);
         dp  = DIFF_WIDTH'(in_window[c][3]) - DIFF_WIDTH'(in_window[c][2]);
         dpp = DIFF_WIDTH'(in_window[c][4]) - DIFF_WIDTH'(in_window[c][3]);
         // ties go left, but a right/center tie goes to the right stencil
         if (mag(dm) <= mag(dp)) begin
            st = (mag(dm - dmm) <= mag(dp - dm)) ? STENCIL_LEFT : STENCIL_CENTER;
         end else begin
            st = (mag(dpp - dp) <= mag(dp - dm)) ? STENCIL_RIGHT : STENCIL_CENTER;
         end
         acc_r = '0;
         acc_l = '0;
         for (int t = 0; t < TAPS; t++) begin
            acc_r = acc_r + SUM_WIDTH'(COEF6[order][SIDE_RIGHT][st][t])
                            * SUM_WIDTH'(in_window[c][t]);
            acc_l = acc_l + SUM_WIDTH'(COEF6[order][SIDE_LEFT][st][t])
                            * SUM_WIDTH'(in_window[c][t]);
         end
         sums_in.right[c] = acc_r;
         sums_in.left[c]  = acc_l;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         sums_ff <= sums_in;
         tag_ff  <= in_tag;
      end
   end

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(tag_ff) && $stable(sums_ff))
      else $error("stencil stage lost a stalled result");

endmodule

@@ sv/eno3_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ENO3 rounding stage
// Divides the face sums by six, rounds half up, saturates and holds the
// result register for the response channel.
// ----------------------------------------------------------------------------
module eno3_round (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  eno3_pkg::sums_type    in_sums,
   input  eno3_pkg::tag_type     in_tag,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output eno3_pkg::faces_type   rsp_faces,
   output eno3_pkg::tag_type     rsp_tag
);
   import eno3_pkg::*;

   localparam int T_WIDTH  = SUM_WIDTH + 1;
   localparam int X_WIDTH  = VALUE_WIDTH + 2;
   localparam int LO_BITS  = X_WIDTH / 2;
   localparam int HI_BITS  = X_WIDTH - LO_BITS;
   localparam int Y_WIDTH  = HI_BITS + 3;
   localparam int DIV_K    = (1 << LO_BITS) / 3;
   localparam int DIV_R    = (1 << LO_BITS) % 3;
   localparam int DIV_OFF  = 3 * (1 << (HI_BITS - 1));
   localparam int RECIP3   = (1 << Y_WIDTH) / 3 + 1;
   localparam logic signed [T_WIDTH-1:0] T_MAX = T_WIDTH'(3) << VALUE_WIDTH;
   localparam logic signed [T_WIDTH-1:0] T_MIN = -T_MAX;
   localparam value_type VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   logic      valid_ff;
   faces_type faces_ff, faces_in;
   tag_type   tag_ff;

   // floor((s + 3) / 6): halve, then split the word so that each divide by
   // three is a narrow multiply
   function automatic value_type round6(input sum_type s);
      logic signed [T_WIDTH-1:0] t;
      logic signed [X_WIDTH-1:0] x;
      logic signed [HI_BITS-1:0] a;
      logic [LO_BITS-1:0]        b;
      logic [Y_WIDTH-1:0]        y;
      logic [2*Y_WIDTH-1:0]      y_prod;
      logic [Y_WIDTH-1:0]        yq;
      logic [X_WIDTH-1:0]        q;
      value_type                 res;
      t = T_WIDTH'(s) + T_WIDTH'(3);
      x = X_WIDTH'(t >>> 1);
      a = x[X_WIDTH-1:LO_BITS];
      b = x[LO_BITS-1:0];
      y = Y_WIDTH'(a) * Y_WIDTH'(DIV_R) + Y_WIDTH'(b) + Y_WIDTH'(DIV_OFF);
      y_prod = (2*Y_WIDTH)'(y) * (2*Y_WIDTH)'(RECIP3);
      yq = y_prod[2*Y_WIDTH-1:Y_WIDTH];
      q = X_WIDTH'(a) * X_WIDTH'(DIV_K) + X_WIDTH'(yq) - X_WIDTH'(DIV_OFF / 3);
      if (t >= T_MAX) begin
         res = VALUE_MAX;
      end else if (t < T_MIN) begin
         res = VALUE_MIN;
      end else begin
         res = q[VALUE_WIDTH-1:0];
      end
      return res;
   endfunction

   assign in_ready  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_faces = faces_ff;
   assign rsp_tag   = tag_ff;

   always_comb begin
      for (int c = 0; c < COMPS; c++) begin
         faces_in.right[c] = round6(in_sums.right[c]);
         faces_in.left[c]  = round6(in_sums.left[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         faces_ff <= faces_in;
         tag_ff   <= in_tag;
      end
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ENO3 interface reconstruction testbench
// Streams rows of cell averages through the reconstruction block and checks
// every right/left face value and flag against a behavioral predictor.
// A directed table covers extremes, short rows, restarts and saturation.
// Random rows follow in both orders, under random idling on both sides, a
// long receiver stall and a sender pause.
// ----------------------------------------------------------------------------
module testbench;
   import eno3_pkg::*;

   localparam int  WATCHDOG_LIMIT = 1000;
   localparam int  SETTLE_CYCLES  = 8;
   localparam int  RECEIVER_HOLD  = 64;
   localparam int  COMPONENTS     = 3;
   localparam int  WINDOW_TAPS    = 5;
   localparam longint FACE_MAX    = 64'sd2147483647;
   localparam longint FACE_MIN    = -64'sd2147483648;

   // face weights in sixths: [order][side][stencil][tap]
   localparam int FACE_SIXTHS [2][2][3][WINDOW_TAPS] = '{
      '{ '{ '{0, 0, 3, 3, 0}, '{0, -3, 9, 0, 0}, '{0, -3, 9, 0, 0} },
         '{ '{0, 0, 9, -3, 0}, '{0, 3, 3, 0, 0}, '{0, 3, 3, 0, 0} } },
      '{ '{ '{0, 0, 2, 5, -1}, '{0, -1, 5, 2, 0}, '{2, -7, 11, 0, 0} },
         '{ '{0, 0, 11, -7, 2}, '{0, 2, 5, -1, 0}, '{-1, 5, 2, 0, 0} } }
   };

   localparam value_type EXTREME_VALUES [5] = '{
      32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF, 32'sh0001_0000
   };

   typedef struct packed {
      value_type [COMPONENTS-1:0] right;
      value_type [COMPONENTS-1:0] left;
      logic                       last_in_run;
      logic                       row_done;
   } result_type;

   typedef struct packed {
      value_type density;
      value_type momentum;
      value_type energy;
      logic      first_cell;
      logic      last_cell;
      logic      typed;        // single-cell row with a known flat result
      value_type typed_value;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 20;
   localparam directed_row_type DIRECTED_CELLS [DIRECTED_COUNT] = '{
      '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 1'b1, 1'b1, 32'sh7FFF_FFFF},
      '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1, 1'b1, 1'b1, 32'sh8000_0000},
      // no row open and no first flag: still opens a row
      '{32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b0, 1'b1, 1'b1, 32'sh0000_0000},
      '{32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'shFFFF_FFFF},
      // two-cell row
      '{32'sh0001_0000, 32'shFFFF_0000, 32'sh0003_0000, 1'b1, 1'b0, 1'b0, '0},
      '{32'sh0005_8000, 32'sh0002_0000, 32'sh0003_0000, 1'b0, 1'b1, 1'b0, '0},
      // abandoned row, dropped by the next first cell
      '{32'sh1234_5678, 32'sh9ABC_DEF0, 32'sh0F0F_0F0F, 1'b1, 1'b0, 1'b0, '0},
      '{32'sh2345_6789, 32'sh8765_4321, 32'shF0F0_F0F0, 1'b0, 1'b0, 1'b0, '0},
      '{32'sh0000_8000, 32'shFFFF_8000, 32'sh5555_5555, 1'b1, 1'b0, 1'b0, '0},
      '{32'sh0001_8000, 32'sh0000_0001, 32'shAAAA_AAAA, 1'b0, 1'b0, 1'b0, '0},
      '{32'sh0003_0000, 32'sh7FFF_0000, 32'sh0F0F_0F0F, 1'b0, 1'b1, 1'b0, '0},
      // full-scale ramp and sawtooth: saturation on both rails
      '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0001_0000, 1'b1, 1'b0, 1'b0, '0},
      '{32'shC000_0000, 32'sh8000_0000, 32'sh0001_0000, 1'b0, 1'b0, 1'b0, '0},
      '{32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh0001_0000, 1'b0, 1'b0, 1'b0, '0},
      '{32'sh4000_0000, 32'sh8000_0000, 32'sh0001_0000, 1'b0, 1'b0, 1'b0, '0},
      '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0001_0000, 1'b0, 1'b1, 1'b0, '0},
      '{32'sh0001_0000, 32'sh0005_0000, 32'sh0000_0000, 1'b1, 1'b0, 1'b0, '0},
      '{32'sh0002_0000, 32'sh0005_0000, 32'shFFFF_0000, 1'b0, 1'b0, 1'b0, '0},
      '{32'sh0004_0000, 32'sh0003_0000, 32'sh0000_0000, 1'b0, 1'b0, 1'b0, '0},
      '{32'sh0008_0000, 32'sh0003_0000, 32'shFFFF_0000, 1'b0, 1'b1, 1'b0, '0}
   };

   logic      clock;
   logic      reset            = 1'b1;
   logic      req_valid        = 1'b0;
   logic      req_ready;
   value_type req_density      = '0;
   value_type req_momentum     = '0;
   value_type req_energy       = '0;
   logic      req_first_cell   = 1'b0;
   logic      req_last_cell    = 1'b0;
   logic      rsp_valid;
   logic      rsp_ready        = 1'b0;
   value_type rsp_right_face_density;
   value_type rsp_right_face_momentum;
   value_type rsp_right_face_energy;
   value_type rsp_left_face_density;
   value_type rsp_left_face_momentum;
   value_type rsp_left_face_energy;
   logic      rsp_last_in_run;
   logic      rsp_row_done;
   logic      csr_write_enable = 1'b0;
   logic      csr_write_data   = 1'b0;

   // travels with the request payload
   logic      cell_typed       = 1'b0;
   value_type cell_typed_value = '0;

   bit        steady_stretch   = 1'b0;
   bit        hold_requested   = 1'b0;
   int        stall_cycles     = 0;
   int        mismatch_count   = 0;
   string     component_name [COMPONENTS] = '{"density", "momentum", "energy"};

   // predictor state
   longint     cell_taps [COMPONENTS][WINDOW_TAPS];
   int         row_cells;
   logic       order_sel;
   result_type expected_faces [$];

   eno3_interface_reconstruction_top dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_density             (req_density),
      .req_momentum            (req_momentum),
      .req_energy              (req_energy),
      .req_first_cell          (req_first_cell),
      .req_last_cell           (req_last_cell),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_right_face_density  (rsp_right_face_density),
      .rsp_right_face_momentum (rsp_right_face_momentum),
      .rsp_right_face_energy   (rsp_right_face_energy),
      .rsp_left_face_density   (rsp_left_face_density),
      .rsp_left_face_momentum  (rsp_left_face_momentum),
      .rsp_left_face_energy    (rsp_left_face_energy),
      .rsp_last_in_run         (rsp_last_in_run),
      .rsp_row_done            (rsp_row_done),
      .csr_write_enable        (csr_write_enable),
      .csr_write_data          (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint magnitude(longint x);
      return (x < 0) ? -x : x;
   endfunction

   // divide by six, round half up, clamp to the value range
   function automatic value_type round_sixths(longint sum6);
      longint q;
      longint r;
      q = sum6 / 6;
      r = sum6 % 6;
      if (r < 0) begin
         q = q - 1;
         r = r + 6;
      end
      if (r >= 3)
         q = q + 1;
      if (q > FACE_MAX)
         q = FACE_MAX;
      if (q < FACE_MIN)
         q = FACE_MIN;
      return value_type'(q);
   endfunction

   function automatic result_type reconstruct_cell(logic last_run, logic done);
      result_type  f;
      longint      dmm, dm, dp, dpp, sum_r, sum_l;
      stencil_type st;
      for (int c = 0; c < COMPONENTS; c++) begin
         dmm = cell_taps[c][1] - cell_taps[c][0];
         dm  = cell_taps[c][2] - cell_taps[c][1];
         dp  = cell_taps[c][3] - cell_taps[c][2];
         dpp = cell_taps[c][4] - cell_taps[c][3];
         // ties go left, but a right/center tie goes to the right stencil
         if (magnitude(dm) <= magnitude(dp))
            st = (magnitude(dm - dmm) <= magnitude(dp - dm)) ? STENCIL_LEFT : STENCIL_CENTER;
         else
            st = (magnitude(dpp - dp) <= magnitude(dp - dm)) ? STENCIL_RIGHT : STENCIL_CENTER;
         sum_r = 0;
         sum_l = 0;
         for (int t = 0; t < WINDOW_TAPS; t++) begin
            sum_r += longint'(FACE_SIXTHS[order_sel][SIDE_RIGHT][st][t]) * cell_taps[c][t];
            sum_l += longint'(FACE_SIXTHS[order_sel][SIDE_LEFT][st][t]) * cell_taps[c][t];
         end
         f.right[c] = round_sixths(sum_r);
         f.left[c]  = round_sixths(sum_l);
      end
      f.last_in_run = last_run;
      f.row_done    = done;
      return f;
   endfunction

   function automatic void queue_result(result_type f);
      expected_faces.insert(expected_faces.size(), f);
   endfunction

   // shift left; the newest tap stays, which also replicates the row edge
   task automatic slide_window();
      for (int c = 0; c < COMPONENTS; c++)
         for (int t = 0; t < WINDOW_TAPS - 1; t++)
            cell_taps[c][t] = cell_taps[c][t + 1];
   endtask

   task automatic predict_cell(value_type d, value_type m, value_type e,
                               logic first, logic last);
      longint v [COMPONENTS];
      v[0] = d;
      v[1] = m;
      v[2] = e;
      if (first || row_cells == 0) begin
         for (int c = 0; c < COMPONENTS; c++)
            for (int t = 0; t < WINDOW_TAPS; t++)
               cell_taps[c][t] = v[c];
         row_cells = 1;
      end else begin
         slide_window();
         for (int c = 0; c < COMPONENTS; c++)
            cell_taps[c][WINDOW_TAPS - 1] = v[c];
         if (row_cells < 7)
            row_cells++;
      end
      if (!last) begin
         if (row_cells >= 3)
            queue_result(reconstruct_cell(1'b1, 1'b0));
      end else begin
         if (row_cells >= 3)
            queue_result(reconstruct_cell(1'b0, 1'b0));
         slide_window();
         if (row_cells >= 2)
            queue_result(reconstruct_cell(1'b0, 1'b0));
         slide_window();
         queue_result(reconstruct_cell(1'b1, 1'b1));
         row_cells = 0;
      end
   endtask

   task automatic compare_field(string field_name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field_name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_and_predict
      result_type seen;
      result_type want;
      if (reset) begin
         for (int c = 0; c < COMPONENTS; c++)
            for (int t = 0; t < WINDOW_TAPS; t++)
               cell_taps[c][t] = 0;
         row_cells    = 0;
         order_sel    = ORDER_THIRD;
         stall_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.right = {rsp_right_face_energy, rsp_right_face_momentum,
                          rsp_right_face_density};
            seen.left  = {rsp_left_face_energy, rsp_left_face_momentum,
                          rsp_left_face_density};
            seen.last_in_run = rsp_last_in_run;
            seen.row_done    = rsp_row_done;
            if (expected_faces.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, expected none, actual %h", $time, seen);
            end else begin
               want = expected_faces.pop_front();
               for (int c = 0; c < COMPONENTS; c++) begin
                  compare_field({component_name[c], " right face"}, want.right[c],
                                seen.right[c]);
                  compare_field({component_name[c], " left face"}, want.left[c],
                                seen.left[c]);
               end
               compare_field("last_in_run", 32'(want.last_in_run), 32'(seen.last_in_run));
               compare_field("row_done", 32'(want.row_done), 32'(seen.row_done));
            end
         end
         if (req_valid && req_ready) begin
            predict_cell(req_density, req_momentum, req_energy, req_first_cell,
                         req_last_cell);
            if (cell_typed) begin
               want.right       = {COMPONENTS{cell_typed_value}};
               want.left        = {COMPONENTS{cell_typed_value}};
               want.last_in_run = 1'b1;
               want.row_done    = 1'b1;
               expected_faces[expected_faces.size() - 1] = want;
            end
         end
         if (csr_write_enable)
            order_sel = csr_write_data;
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
   end

   initial begin : watchdog
      wait (stall_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no request or result accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : receiver
      forever begin
         @(negedge clock);
         if (hold_requested) begin
            hold_requested = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RECEIVER_HOLD) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= steady_stretch || ($urandom_range(99) >= 30);
         end
      end
   end

   task automatic send_cell(value_type d, value_type m, value_type e, logic first,
                            logic last, logic typed, value_type typed_value);
      @(negedge clock);
      while (!steady_stretch && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_density      <= d;
      req_momentum     <= m;
      req_energy       <= e;
      req_first_cell   <= first;
      req_last_cell    <= last;
      cell_typed       <= typed;
      cell_typed_value <= typed_value;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (expected_faces.size() == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_order(logic order);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= order;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_random_rows(int cell_budget);
      int        sent;
      int        row_len;
      int        shape [COMPONENTS];
      value_type level [COMPONENTS];
      value_type slope [COMPONENTS];
      value_type v [COMPONENTS];
      logic      broken;
      logic      first;
      sent = 0;
      while (sent < cell_budget) begin
         row_len = ($urandom_range(99) < 85) ? $urandom_range(8, 1) : $urandom_range(24, 9);
         broken  = ($urandom_range(11) == 0);
         for (int c = 0; c < COMPONENTS; c++) begin
            shape[c] = $urandom_range(3);
            level[c] = $urandom();
            slope[c] = $urandom_range(32'h0004_0000) - 32'h0002_0000;
         end
         for (int i = 0; i < row_len; i++) begin
            for (int c = 0; c < COMPONENTS; c++) begin
               case (shape[c])
                  0: v[c] = $urandom();
                  1: begin
                     level[c] += slope[c];
                     slope[c] += $urandom_range(32'h800) - 32'h400;
                     v[c] = level[c];
                  end
                  2: v[c] = EXTREME_VALUES[$urandom_range(4)];
                  default: begin
                     // smooth with an occasional shock
                     if ($urandom_range(4) == 0)
                        level[c] = $urandom();
                     else
                        level[c] += slope[c];
                     v[c] = level[c];
                  end
               endcase
            end
            first = (i == 0) ? ($urandom_range(7) != 0) : ($urandom_range(39) == 0);
            send_cell(v[0], v[1], v[2], first, (i == row_len - 1) && !broken, 1'b0, '0);
            sent++;
         end
      end
      // close whatever row is open
      send_cell($urandom(), $urandom(), $urandom(), 1'($urandom_range(1)), 1'b1, 1'b0, '0);
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_order(ORDER_THIRD);
      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_cell(DIRECTED_CELLS[i].density, DIRECTED_CELLS[i].momentum,
                   DIRECTED_CELLS[i].energy, DIRECTED_CELLS[i].first_cell,
                   DIRECTED_CELLS[i].last_cell, DIRECTED_CELLS[i].typed,
                   DIRECTED_CELLS[i].typed_value);
      settle();

      write_order(ORDER_SECOND);
      send_random_rows(90);
      settle();

      write_order(ORDER_THIRD);
      steady_stretch = 1'b1;
      send_random_rows(35);
      // receiver stalls while requests keep coming
      hold_requested = 1'b1;
      send_random_rows(20);
      steady_stretch = 1'b0;
      send_random_rows(25);
      settle();
      send_random_rows(30);
      settle();

      mismatch_count += expected_faces.size();
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/eno3_pkg.sv
sv/eno3_window.sv
sv/eno3_stencil.sv
sv/eno3_round.sv
sv/eno3_interface_reconstruction_top.sv
test/testbench.sv
